/* design/i2crr_pkg.sv */
// ----------------------------------------------------------------------------
// i2crr_pkg
// Shared types and widths for the I2C register-read master.
// ----------------------------------------------------------------------------
package i2crr_pkg;

  localparam int unsigned DEV_W  = 7;
  localparam int unsigned REG_W  = 16;
  localparam int unsigned BYTE_W = 8;

  // one quarter-bit tick with an optional read request
  typedef struct packed {
    logic              action;
    logic [DEV_W-1:0]  device_address;
    logic [REG_W-1:0]  register_address;
    logic              wide_register;
    logic              sda_sense;
  } item_t;

  // bus drive and status after one tick
  typedef struct packed {
    logic              scl_release;
    logic              sda_release;
    logic              busy_res;
    logic              done_res;
    logic              nacked;
    logic [BYTE_W-1:0] read_byte;
  } res_t;

endpackage

/* design/i2crr_core.sv */
// ----------------------------------------------------------------------------
// i2crr_core
// Bus sequencer: advances the start / address / register / read / stop
// sequence by one quarter-bit on each fired item and forms its result.
// ----------------------------------------------------------------------------
module i2crr_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  i2crr_pkg::item_t item_i,
  output i2crr_pkg::res_t  res_o
);

  typedef enum logic [3:0] {
    K_IDLE  = 4'd0,
    K_START = 4'd1,
    K_WRITE = 4'd2,
    K_ACK   = 4'd3,
    K_READ  = 4'd4,
    K_NACK  = 4'd5,
    K_STOP  = 4'd6
  } kind_e;

  kind_e                            kind_q, kind_d;
  logic [1:0]                       qtr_q, qtr_d;
  logic [3:0]                       cnt_q, cnt_d;
  logic [i2crr_pkg::BYTE_W-1:0]     shreg_q, shreg_d;
  logic [2:0]                       stage_q, stage_d;
  logic [i2crr_pkg::DEV_W-1:0]      dev_q, dev_d;
  logic [i2crr_pkg::REG_W-1:0]      radr_q, radr_d;
  logic                             wide_q, wide_d;
  logic                             scl_q, scl_d;
  logic                             sda_q, sda_d;
  logic                             err_q, err_d;
  logic                             done;
  logic [i2crr_pkg::BYTE_W-1:0]     rb;

  always_comb begin
    kind_d  = kind_q;
    qtr_d   = qtr_q;
    cnt_d   = cnt_q;
    shreg_d = shreg_q;
    stage_d = stage_q;
    dev_d   = dev_q;
    radr_d  = radr_q;
    wide_d  = wide_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    err_d   = err_q;
    done    = 1'b0;
    rb      = '0;

    // request latches and runs the first start quarter on the same tick
    if (kind_q == K_IDLE && item_i.action) begin
      dev_d   = item_i.device_address;
      radr_d  = item_i.register_address;
      wide_d  = item_i.wide_register;
      err_d   = 1'b0;
      stage_d = 3'd0;
      shreg_d = {item_i.device_address, 1'b0};
      cnt_d   = '0;
      kind_d  = K_START;
      qtr_d   = 2'd0;
    end

    unique case (kind_d)
      K_IDLE: begin
        qtr_d = 2'd0;
        scl_d = 1'b1;
        sda_d = 1'b1;
      end
      K_START: begin
        unique case (qtr_d)
          2'd0: sda_d = 1'b1;
          2'd1: scl_d = 1'b1;
          2'd2: sda_d = 1'b0;
          2'd3: scl_d = 1'b0;
        endcase
        if (qtr_d == 2'd3) begin
          kind_d = K_WRITE;
          qtr_d  = 2'd0;
        end else begin
          qtr_d = qtr_d + 2'd1;
        end
      end
      K_WRITE: begin
        if (qtr_d == 2'd0) sda_d = shreg_d[i2crr_pkg::BYTE_W-1];
        if (qtr_d == 2'd1) scl_d = 1'b1;
        if (qtr_d == 2'd3) begin
          scl_d   = 1'b0;
          shreg_d = {shreg_d[i2crr_pkg::BYTE_W-2:0], 1'b0};
          cnt_d   = cnt_d + 4'd1;
          kind_d  = (cnt_d >= 4'd8) ? K_ACK : K_WRITE;
          qtr_d   = 2'd0;
        end else begin
          qtr_d = qtr_d + 2'd1;
        end
      end
      K_ACK: begin
        if (qtr_d == 2'd0) sda_d = 1'b1;
        if (qtr_d == 2'd1) scl_d = 1'b1;
        if (qtr_d == 2'd2 && item_i.sda_sense) err_d = 1'b1;
        if (qtr_d == 2'd3) begin
          scl_d = 1'b0;
          qtr_d = 2'd0;
          cnt_d = '0;
          if (err_d) begin
            kind_d = K_STOP;
          end else begin
            unique case (stage_d)
              3'd0: begin
                kind_d  = K_WRITE;
                stage_d = wide_d ? 3'd1 : 3'd2;
                shreg_d = wide_d ? radr_d[15:8] : radr_d[7:0];
              end
              3'd1: begin
                kind_d  = K_WRITE;
                stage_d = 3'd2;
                shreg_d = radr_d[7:0];
              end
              3'd2: begin
                kind_d  = K_START;
                stage_d = 3'd3;
                shreg_d = {dev_d, 1'b1};
              end
              3'd3: begin
                kind_d  = K_READ;
                stage_d = 3'd4;
                shreg_d = '0;
              end
              default: begin
                err_d  = 1'b1;
                kind_d = K_STOP;
              end
            endcase
          end
        end else begin
          qtr_d = qtr_d + 2'd1;
        end
      end
      K_READ: begin
        if (qtr_d == 2'd0) sda_d = 1'b1;
        if (qtr_d == 2'd1) scl_d = 1'b1;
        if (qtr_d == 2'd2) shreg_d = {shreg_d[i2crr_pkg::BYTE_W-2:0], item_i.sda_sense};
        if (qtr_d == 2'd3) begin
          scl_d  = 1'b0;
          cnt_d  = cnt_d + 4'd1;
          kind_d = (cnt_d >= 4'd8) ? K_NACK : K_READ;
          qtr_d  = 2'd0;
        end else begin
          qtr_d = qtr_d + 2'd1;
        end
      end
      K_NACK: begin
        if (qtr_d == 2'd0) sda_d = 1'b1;
        if (qtr_d == 2'd1) scl_d = 1'b1;
        if (qtr_d == 2'd3) begin
          scl_d  = 1'b0;
          kind_d = K_STOP;
          qtr_d  = 2'd0;
        end else begin
          qtr_d = qtr_d + 2'd1;
        end
      end
      K_STOP: begin
        if (qtr_d == 2'd0) begin
          sda_d = 1'b0;
          qtr_d = 2'd1;
        end else if (qtr_d == 2'd1) begin
          scl_d = 1'b1;
          qtr_d = 2'd2;
        end else begin
          sda_d  = 1'b1;
          scl_d  = 1'b1;
          done   = 1'b1;
          rb     = err_d ? '0 : shreg_d;
          kind_d = K_IDLE;
          qtr_d  = 2'd0;
        end
      end
      default: begin
        kind_d = K_STOP;
        qtr_d  = 2'd0;
      end
    endcase
  end

  always_comb begin
    res_o.scl_release = scl_d;
    res_o.sda_release = sda_d;
    res_o.busy_res    = (kind_d != K_IDLE);
    res_o.done_res    = done;
    res_o.nacked      = done & err_d;
    res_o.read_byte   = rb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= K_IDLE;
      qtr_q   <= 2'd0;
      cnt_q   <= '0;
      shreg_q <= '0;
      stage_q <= '0;
      dev_q   <= '0;
      radr_q  <= '0;
      wide_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      err_q   <= 1'b0;
    end else if (fire_i) begin
      kind_q  <= kind_d;
      qtr_q   <= qtr_d;
      cnt_q   <= cnt_d;
      shreg_q <= shreg_d;
      stage_q <= stage_d;
      dev_q   <= dev_d;
      radr_q  <= radr_d;
      wide_q  <= wide_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      err_q   <= err_d;
    end
  end

endmodule

/* design/i2c_master_register_read_top.sv */
// Path: an accepted item goes through the input register, then the result register;
//   it waits in the input register while the output stalls.
// Throughput: one item per cycle while the output does not stall; the sequencer steps once per item.
// Reset: rst_ni low clears the sequencer to idle with SCL and SDA
//   released and empties both registers.
// ----------------------------------------------------------------------------
// i2c_master_register_read_top
// I2C master reading one device register, one quarter-bit tick per item.
// ----------------------------------------------------------------------------
module i2c_master_register_read_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [i2crr_pkg::DEV_W-1:0]    device_address_i,
  input  logic [i2crr_pkg::REG_W-1:0]    register_address_i,
  input  logic                           wide_register_i,
  input  logic                           sda_sense_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           scl_release_o,
  output logic                           sda_release_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic                           nacked_o,
  output logic [i2crr_pkg::BYTE_W-1:0]   read_byte_o
);

  i2crr_pkg::item_t item_q;
  logic             in_vld_q;
  i2crr_pkg::res_t  res, res_q;
  logic             out_vld_q;
  logic             fire;
  logic             accept;

  // item in the input register steps the sequencer when the result slot frees
  assign fire       = in_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = in_vld_q & ~fire;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action           <= action_i;
      item_q.device_address   <= device_address_i;
      item_q.register_address <= register_address_i;
      item_q.wide_register    <= wide_register_i;
      item_q.sda_sense        <= sda_sense_i;
    end
  end

  i2crr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign scl_release_o = res_q.scl_release;
  assign sda_release_o = res_q.sda_release;
  assign busy_res_o    = res_q.busy_res;
  assign done_res_o    = res_q.done_res;
  assign nacked_o      = res_q.nacked;
  assign read_byte_o   = res_q.read_byte;

endmodule

/* design/i2crr_checker.sv */
// ----------------------------------------------------------------------------
// i2crr_checker
// Port-level checks on the I2C register-read master, bound to the top level.
// ----------------------------------------------------------------------------
module i2crr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         scl_release_o,
  input logic                         sda_release_o,
  input logic                         busy_res_o,
  input logic                         done_res_o,
  input logic                         nacked_o,
  input logic [i2crr_pkg::BYTE_W-1:0] read_byte_o
);

  // a finished transfer is no longer busy and leaves the bus released
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o && scl_release_o && sda_release_o)
    else $error("done item still busy or bus held");

  a_nack_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nacked_o |-> done_res_o && (read_byte_o == '0))
    else $error("nack outside done or with data");

  a_byte_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_byte_o != '0) |-> done_res_o)
    else $error("read byte outside done");

  // clock held low only mid-transfer, never on a done item
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && busy_res_o && !scl_release_o |-> !done_res_o)
    else $error("clock held low on done item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled item dropped");

endmodule

bind i2c_master_register_read_top i2crr_checker u_i2crr_checker (.*);
